// ===== hdl/two_fluid_plasma_flux_assert.svh =====
// Assertion macros shared by the checker of the two-fluid plasma flux block.
`ifndef TWO_FLUID_PLASMA_FLUX_ASSERT_SVH
`define TWO_FLUID_PLASMA_FLUX_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TFPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TFPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/tfpf_pkg.sv =====
// Types, constants and saturating fixed-point helpers of the plasma flux block.
package tfpf_pkg;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int GAMMA_W   = 19;
  localparam int LIGHT_W   = 25;
  localparam int ADDR_W    = 3;
  localparam int DIV_STEPS = DW;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int FLUX_LAT  = 9;
  localparam int PIPE_LAT  = DIV_LAT + FLUX_LAT;

  localparam logic [GAMMA_W-1:0] GAMMA_RST = GAMMA_W'(109227);
  localparam logic [LIGHT_W-1:0] LIGHT_RST = LIGHT_W'(65536);

  typedef enum logic {
    REG_GAMMA = 1'b0,
    REG_LIGHT = 1'b1
  } tfpf_reg_e;

  typedef logic signed [DW-1:0] tfpf_word_t;

  typedef struct packed {
    tfpf_word_t density;
    tfpf_word_t momentum_x;
    tfpf_word_t momentum_y;
    tfpf_word_t momentum_z;
    tfpf_word_t total_energy;
    tfpf_word_t mag_y;
    tfpf_word_t mag_z;
    tfpf_word_t elec_y;
    tfpf_word_t elec_z;
  } tfpf_in_t;

  typedef struct packed {
    tfpf_word_t mass_flux;
    tfpf_word_t xmom_flux;
    tfpf_word_t ymom_flux;
    tfpf_word_t zmom_flux;
    tfpf_word_t energy_flux;
    tfpf_word_t mag_y_flux;
    tfpf_word_t mag_z_flux;
    tfpf_word_t elec_y_flux;
    tfpf_word_t elec_z_flux;
    logic       density_error;
    logic       saturated;
  } tfpf_out_t;

  // Item context that rides alongside the divider.
  typedef struct packed {
    tfpf_word_t mx;
    tfpf_word_t my;
    tfpf_word_t mz;
    tfpf_word_t en;
    tfpf_word_t by;
    tfpf_word_t bz;
    tfpf_word_t ey;
    tfpf_word_t ez;
    logic       err;
  } tfpf_ctx_t;

  typedef struct packed {
    logic              neg;
    logic [2*DW-1:0]   mag;
  } tfpf_prod_t;

  typedef struct packed {
    logic       clip;
    tfpf_word_t val;
  } tfpf_sat_t;

  function automatic logic [DW-1:0] abs_mag(tfpf_word_t a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic tfpf_prod_t mul_raw(tfpf_word_t a, tfpf_word_t b);
    tfpf_prod_t      r;
    logic [2*DW-1:0] ax;
    logic [2*DW-1:0] bx;
    ax    = {{DW{1'b0}}, abs_mag(a)};
    bx    = {{DW{1'b0}}, abs_mag(b)};
    r.neg = a[DW-1] ^ b[DW-1];
    r.mag = ax * bx;
    return r;
  endfunction

  // Round to nearest, ties away from zero, drop FB bits and clip.
  function automatic tfpf_sat_t rnd(tfpf_prod_t p);
    tfpf_sat_t        r;
    logic [2*DW:0]    t;
    logic [2*DW-FB:0] v;
    logic [2*DW-FB:0] lim;
    t = {1'b0, p.mag} + ((2*DW+1)'(1) << (FB-1));
    v = t[2*DW:FB];
    lim = '0;
    lim[DW-1] = 1'b1;
    if (!p.neg) begin
      lim = lim - 1'b1;
    end
    r.clip = (v > lim);
    if (r.clip) begin
      v = lim;
    end
    r.val = p.neg ? (~v[DW-1:0] + 1'b1) : v[DW-1:0];
    return r;
  endfunction

  function automatic tfpf_sat_t sat_sum(logic signed [DW:0] s);
    tfpf_sat_t r;
    r.clip = (s[DW] != s[DW-1]);
    if (r.clip) begin
      r.val = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r.val = s[DW-1:0];
    end
    return r;
  endfunction

  function automatic tfpf_sat_t add_sat(tfpf_word_t a, tfpf_word_t b);
    return sat_sum({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic tfpf_sat_t sub_sat(tfpf_word_t a, tfpf_word_t b);
    return sat_sum({a[DW-1], a} - {b[DW-1], b});
  endfunction

  // Product with one half, rounded like any other product; never clips.
  function automatic tfpf_word_t half(tfpf_word_t a);
    logic [DW:0] m;
    m = ({1'b0, abs_mag(a)} + 1'b1) >> 1;
    return a[DW-1] ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
  endfunction

endpackage

// ===== hdl/two_fluid_plasma_flux.sv =====
// Top level of the two-fluid five-moment x-flux unit with its register port.
//
// This unit takes one species' conserved state with the transverse fields of the same
// point and returns the five Euler fluxes, the four nonzero Maxwell fluxes and two
// flags, all in signed Q16.16. It is fully pipelined: one item can be started in every
// clock cycle, busy is always low, and results leave at the same rate on a one-cycle
// strobe that the receiver cannot hold off. The latency is set mainly by the velocity
// divider, which resolves one quotient bit per stage over 32 stages; the nine stages
// behind it form the products, the pressure and the energy flux, with a register after
// every multiplication. A nonpositive density gives zero fluxes with density_error set.
// Any clipped intermediate sets saturated. The adiabatic index sits at byte address 0
// and the speed of light at 4; write them only while no transfer is in flight.
module two_fluid_plasma_flux (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  tfpf_pkg::tfpf_in_t              in_item_i,
  output logic                            out_valid_o,
  output tfpf_pkg::tfpf_out_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tfpf_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tfpf_pkg::*;

  logic [GAMMA_W-1:0] gamma_q;
  logic [LIGHT_W-1:0] light_q;
  tfpf_reg_e          reg_sel;
  tfpf_prod_t         cprod_q;
  tfpf_sat_t          c2_q;
  tfpf_word_t         gm1;
  tfpf_ctx_t          ctx_d;
  tfpf_ctx_t          ctx_q [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] vld_q;
  logic               accept;
  tfpf_word_t         den;
  tfpf_sat_t          u1, u2, u3;

  // Register port: no wait states, the address bit above the word offset picks the register.
  assign pready  = 1'b1;
  assign reg_sel = tfpf_reg_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_GAMMA: prdata = {{(32-GAMMA_W){1'b0}}, gamma_q};
      REG_LIGHT: prdata = {{(32-LIGHT_W){1'b0}}, light_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
      light_q <= LIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_GAMMA: gamma_q <= pwdata[GAMMA_W-1:0];
        REG_LIGHT: light_q <= pwdata[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Constants derived from the registers: gm1 is combinational and c2 is registered in
  // cprod_q and c2_q; both settle long before an item started after a write reaches them.
  assign gm1 = DW'(gamma_q) - (DW'(1) << FB);

  always_ff @(posedge clk_i) begin
    cprod_q <= mul_raw(DW'(light_q), DW'(light_q));
    c2_q    <= rnd(cprod_q);
  end

  // Every start is taken; the pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ctx_d.mx  = in_item_i.momentum_x;
    ctx_d.my  = in_item_i.momentum_y;
    ctx_d.mz  = in_item_i.momentum_z;
    ctx_d.en  = in_item_i.total_energy;
    ctx_d.by  = in_item_i.mag_y;
    ctx_d.bz  = in_item_i.mag_z;
    ctx_d.ey  = in_item_i.elec_y;
    ctx_d.ez  = in_item_i.elec_z;
    ctx_d.err = (in_item_i.density[DW-1] || (in_item_i.density == '0));
  end

  // The divider needs a positive divisor; an item in error uses one, and its quotient
  // is discarded at the end of the flux pipeline.
  assign den = ctx_d.err ? DW'(1) : in_item_i.density;

  tfpf_div u_div1 (.clk_i, .num_i(in_item_i.momentum_x), .den_i(den), .quo_o(u1));
  tfpf_div u_div2 (.clk_i, .num_i(in_item_i.momentum_y), .den_i(den), .quo_o(u2));
  tfpf_div u_div3 (.clk_i, .num_i(in_item_i.momentum_z), .den_i(den), .quo_o(u3));

  // The item context travels beside the dividers with its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_d;
    for (int i = 1; i < DIV_LAT; i++) begin
      ctx_q[i] <= ctx_q[i-1];
    end
  end

  tfpf_flux u_flux (
    .clk_i,
    .rst_ni,
    .vld_i       (vld_q[DIV_LAT-1]),
    .ctx_i       (ctx_q[DIV_LAT-1]),
    .u1_i        (u1),
    .u2_i        (u2),
    .u3_i        (u3),
    .gm1_i       (gm1),
    .c2_i        (c2_q),
    .out_valid_o,
    .out_item_o
  );

endmodule

// ===== hdl/tfpf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and clipped.
module tfpf_div (
  input  logic                clk_i,
  input  tfpf_pkg::tfpf_word_t num_i,
  input  tfpf_pkg::tfpf_word_t den_i,
  output tfpf_pkg::tfpf_sat_t  quo_o
);
  import tfpf_pkg::*;

  logic              neg_q  [0:DIV_STEPS];
  logic              ovf_q  [0:DIV_STEPS];
  logic [DW-2:0]     den_q  [0:DIV_STEPS];
  logic [DW-2:0]     rem_q  [0:DIV_STEPS];
  logic [DW-1:0]     tail_q [0:DIV_STEPS];
  logic [DW-1:0]     quo_q  [0:DIV_STEPS];
  tfpf_sat_t         quo_d;
  tfpf_sat_t         res_q;
  logic [DW-1:0]     x;

  assign x = abs_mag(num_i);

  // A quotient of 2^DW or more shows when the upper bits alone reach the divisor.
  always_ff @(posedge clk_i) begin
    neg_q[0]  <= num_i[DW-1];
    den_q[0]  <= den_i[DW-2:0];
    ovf_q[0]  <= ({{(DW-FB){1'b0}}, x[DW-1:DW-FB]} >= den_i);
    rem_q[0]  <= {{(DW-1-FB){1'b0}}, x[DW-1:DW-FB]};
    tail_q[0] <= {x[DW-FB-1:0], {FB{1'b0}}};
    quo_q[0]  <= '0;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DW-1:0] t;
    logic [DW-1:0] dif;
    logic          ge;
    assign t   = {rem_q[k], tail_q[k][DW-1]};
    assign dif = t - {1'b0, den_q[k]};
    assign ge  = (t >= {1'b0, den_q[k]});
    always_ff @(posedge clk_i) begin
      neg_q[k+1]  <= neg_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      den_q[k+1]  <= den_q[k];
      rem_q[k+1]  <= ge ? dif[DW-2:0] : t[DW-2:0];
      tail_q[k+1] <= {tail_q[k][DW-2:0], 1'b0};
      quo_q[k+1]  <= {quo_q[k][DW-2:0], ge};
    end
  end

  always_comb begin
    logic [DW:0] qm;
    logic [DW:0] lim;
    qm  = {1'b0, quo_q[DIV_STEPS]} +
          {{DW{1'b0}}, ({rem_q[DIV_STEPS], 1'b0} >= {1'b0, den_q[DIV_STEPS]})};
    lim = {2'b01, {(DW-1){1'b0}}};
    if (!neg_q[DIV_STEPS]) begin
      lim = lim - 1'b1;
    end
    quo_d.clip = ovf_q[DIV_STEPS] || (qm > lim);
    if (quo_d.clip) begin
      qm = lim;
    end
    quo_d.val = neg_q[DIV_STEPS] ? (~qm[DW-1:0] + 1'b1) : qm[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= quo_d;
  end

  assign quo_o = res_q;

endmodule

// ===== hdl/tfpf_flux.sv =====
// Flux pipeline after the velocities: products, pressure, fluxes and final clipping.
module tfpf_flux (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  tfpf_pkg::tfpf_ctx_t  ctx_i,
  input  tfpf_pkg::tfpf_sat_t  u1_i,
  input  tfpf_pkg::tfpf_sat_t  u2_i,
  input  tfpf_pkg::tfpf_sat_t  u3_i,
  input  tfpf_pkg::tfpf_word_t gm1_i,
  input  tfpf_pkg::tfpf_sat_t  c2_i,
  output logic                 out_valid_o,
  output tfpf_pkg::tfpf_out_t  out_item_o
);
  import tfpf_pkg::*;

  logic [FLUX_LAT-1:0] vld_q;

  // Stage 1: raw products.
  tfpf_ctx_t  ctx1_q;
  tfpf_word_t u1_1_q;
  logic       clip1_q;
  tfpf_prod_t p_mxu1_q, p_myu2_q, p_mzu3_q, p_mxu2_q, p_mxu3_q, p_c2bz_q, p_c2by_q;
  // Later stages carry a partly filled result.
  tfpf_out_t  res2_q, res3_q, res4_q, res5_q, res6_q, res7_q, res8_q, res9_q;
  tfpf_out_t  res2_d, res3_d, res4_d, res6_d, res7_d, res9_d;
  tfpf_word_t m1_2_q, m2_2_q, m3_2_q, cby_2_q, ez_2_q;
  tfpf_word_t u1_2_q, en_2_q, m1_3_q, u1_3_q, en_3_q, s_3_q;
  tfpf_word_t m1_4_q, u1_4_q, en_4_q, dd_4_q;
  tfpf_word_t m1_5_q, u1_5_q, en_5_q, m1_6_q, u1_6_q, en_6_q, p_6_q;
  tfpf_word_t u1_7_q, e2_7_q;
  tfpf_prod_t pp_5_q, pe_8_q;
  tfpf_sat_t  m1_s, m2_s, m3_s, ym_s, zm_s, ey_s, cby_s;
  tfpf_sat_t  mgy_s, ezf_s, sa_s, sb_s, dd_s, p_s, xf_s, e2_s, ef_s;

  always_comb begin
    m1_s  = rnd(p_mxu1_q);
    m2_s  = rnd(p_myu2_q);
    m3_s  = rnd(p_mzu3_q);
    ym_s  = rnd(p_mxu2_q);
    zm_s  = rnd(p_mxu3_q);
    ey_s  = rnd(p_c2bz_q);
    cby_s = rnd(p_c2by_q);
    res2_d               = '0;
    res2_d.mass_flux     = ctx1_q.mx;
    res2_d.ymom_flux     = ym_s.val;
    res2_d.zmom_flux     = zm_s.val;
    res2_d.elec_y_flux   = ey_s.val;
    res2_d.mag_z_flux    = ctx1_q.ey;
    res2_d.density_error = ctx1_q.err;
    res2_d.saturated     = clip1_q | m1_s.clip | m2_s.clip | m3_s.clip | ym_s.clip |
                           zm_s.clip | ey_s.clip | cby_s.clip;

    mgy_s = sub_sat('0, ez_2_q);
    ezf_s = sub_sat('0, cby_2_q);
    sa_s  = add_sat(m1_2_q, m2_2_q);
    sb_s  = add_sat(sa_s.val, m3_2_q);
    res3_d             = res2_q;
    res3_d.mag_y_flux  = mgy_s.val;
    res3_d.elec_z_flux = ezf_s.val;
    res3_d.saturated   = res2_q.saturated | mgy_s.clip | ezf_s.clip | sa_s.clip | sb_s.clip;

    dd_s = sub_sat(en_3_q, half(s_3_q));
    res4_d           = res3_q;
    res4_d.saturated = res3_q.saturated | dd_s.clip;

    p_s  = rnd(pp_5_q);
    res6_d           = res5_q;
    res6_d.saturated = res5_q.saturated | p_s.clip;

    xf_s = add_sat(m1_6_q, p_6_q);
    e2_s = add_sat(en_6_q, p_6_q);
    res7_d           = res6_q;
    res7_d.xmom_flux = xf_s.val;
    res7_d.saturated = res6_q.saturated | xf_s.clip | e2_s.clip;

    ef_s = rnd(pe_8_q);
    res9_d             = res8_q;
    res9_d.energy_flux = ef_s.val;
    res9_d.saturated   = res8_q.saturated | ef_s.clip;
    // Nonpositive density: every flux is zero and nothing counts as clipped.
    if (res8_q.density_error) begin
      res9_d               = '0;
      res9_d.density_error = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FLUX_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q   <= ctx_i;
    u1_1_q   <= u1_i.val;
    clip1_q  <= u1_i.clip | u2_i.clip | u3_i.clip | c2_i.clip;
    p_mxu1_q <= mul_raw(ctx_i.mx, u1_i.val);
    p_myu2_q <= mul_raw(ctx_i.my, u2_i.val);
    p_mzu3_q <= mul_raw(ctx_i.mz, u3_i.val);
    p_mxu2_q <= mul_raw(ctx_i.mx, u2_i.val);
    p_mxu3_q <= mul_raw(ctx_i.mx, u3_i.val);
    p_c2bz_q <= mul_raw(c2_i.val, ctx_i.bz);
    p_c2by_q <= mul_raw(c2_i.val, ctx_i.by);

    res2_q  <= res2_d;
    m1_2_q  <= m1_s.val;
    m2_2_q  <= m2_s.val;
    m3_2_q  <= m3_s.val;
    cby_2_q <= cby_s.val;
    ez_2_q  <= ctx1_q.ez;
    u1_2_q  <= u1_1_q;
    en_2_q  <= ctx1_q.en;

    res3_q <= res3_d;
    s_3_q  <= sb_s.val;
    m1_3_q <= m1_2_q;
    u1_3_q <= u1_2_q;
    en_3_q <= en_2_q;

    res4_q <= res4_d;
    dd_4_q <= dd_s.val;
    m1_4_q <= m1_3_q;
    u1_4_q <= u1_3_q;
    en_4_q <= en_3_q;

    res5_q <= res4_q;
    pp_5_q <= mul_raw(gm1_i, dd_4_q);
    m1_5_q <= m1_4_q;
    u1_5_q <= u1_4_q;
    en_5_q <= en_4_q;

    res6_q <= res6_d;
    p_6_q  <= p_s.val;
    m1_6_q <= m1_5_q;
    u1_6_q <= u1_5_q;
    en_6_q <= en_5_q;

    res7_q <= res7_d;
    e2_7_q <= e2_s.val;
    u1_7_q <= u1_6_q;

    res8_q <= res7_q;
    pe_8_q <= mul_raw(u1_7_q, e2_7_q);

    res9_q <= res9_d;
  end

  assign out_valid_o = vld_q[FLUX_LAT-1];
  assign out_item_o  = res9_q;

endmodule

// ===== hdl/tfpf_checker.sv =====
// Port-level checker of the plasma flux block, bound to its top level.
`include "two_fluid_plasma_flux_assert.svh"

module tfpf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input tfpf_pkg::tfpf_in_t  in_item_i,
  input logic                out_valid_o,
  input tfpf_pkg::tfpf_out_t out_item_o
);
  import tfpf_pkg::*;

  `TFPF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

  `TFPF_ASSERT(a_result_has_source, out_valid_o |-> $past(start && !busy, PIPE_LAT), "result without a started item")

  `TFPF_ASSERT(a_bad_density_flagged, (start && !busy && (in_item_i.density[DW-1] || in_item_i.density == '0)) |-> ##PIPE_LAT (out_valid_o && out_item_o.density_error), "nonpositive density not flagged")

  `TFPF_ASSERT(a_error_zeroes, (out_valid_o && out_item_o.density_error) |-> (out_item_o.mass_flux == '0 && out_item_o.energy_flux == '0 && out_item_o.elec_z_flux == '0 && !out_item_o.saturated), "error result not cleared")

  `TFPF_ASSERT(a_mass_flux_passes, (out_valid_o && !out_item_o.density_error) |-> (out_item_o.mass_flux == $past(in_item_i.momentum_x, PIPE_LAT)), "mass flux differs from x momentum")

endmodule

bind two_fluid_plasma_flux tfpf_checker u_tfpf_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the two-fluid plasma flux unit.
`timescale 1ns / 1ps

module tb;
  import tfpf_pkg::*;

  // Clock, reset and the block's ports.
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start = 1'b0;
  logic        busy;
  tfpf_in_t    in_item_i = '0;
  logic        out_valid_o;
  tfpf_out_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_fluid_plasma_flux u_top (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .out_valid_o, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Items waiting to be started, and the flux results owed by the block.
  tfpf_in_t  pending_points[$];
  tfpf_out_t owed_fluxes[$];

  // Shadow copies of the two registers, as the predictor sees them.
  logic [GAMMA_W-1:0] gamma_shadow = GAMMA_RST;
  logic [LIGHT_W-1:0] light_shadow = LIGHT_RST;

  int  send_idle_pct = 0;
  int  error_count = 0;
  int  started_points = 0;
  int  checked_fluxes = 0;
  int  density_errors_seen = 0;
  int  saturations_seen = 0;
  bit  clip_hit;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // Fixed-point helpers of the predictor. Each clip raises clip_hit.
  function automatic longint clip_word(longint v);
    if (v > WORD_MAX) begin
      clip_hit = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clip_hit = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // Signed value from a sign and a wide magnitude, clipped to the word range.
  function automatic longint signed_of(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m > lim) begin
      clip_hit = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] magnitude(longint a);
    return (a < 0) ? 128'(-a) : 128'(a);
  endfunction

  // Product rounded to nearest with ties away from zero.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = magnitude(a) * magnitude(b);
    p = (p + (128'd1 << (FB - 1))) >> FB;
    return signed_of((a < 0) != (b < 0), p);
  endfunction

  // Quotient by a positive density, rounded the same way.
  function automatic longint fx_div(longint a, longint d);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    num = magnitude(a) << FB;
    q = num / 128'(d);
    r = num % 128'(d);
    if (r >= 128'(d) - r) q = q + 1;
    return signed_of(a < 0, q);
  endfunction

  function automatic tfpf_out_t flux_of(tfpf_in_t pt);
    tfpf_out_t o;
    longint rho, mx, my, mz, en, by, bz, ey, ez;
    longint gm1, c2, u1, u2, u3, ke, p;
    o = '0;
    clip_hit = 1'b0;
    rho = longint'(pt.density);
    mx = longint'(pt.momentum_x);
    my = longint'(pt.momentum_y);
    mz = longint'(pt.momentum_z);
    en = longint'(pt.total_energy);
    by = longint'(pt.mag_y);
    bz = longint'(pt.mag_z);
    ey = longint'(pt.elec_y);
    ez = longint'(pt.elec_z);
    if (rho <= 0) begin
      o.density_error = 1'b1;
      return o;
    end
    gm1 = clip_word(longint'(gamma_shadow) - (64'sd1 <<< FB));
    c2 = fx_mul(longint'(light_shadow), longint'(light_shadow));
    u1 = fx_div(mx, rho);
    u2 = fx_div(my, rho);
    u3 = fx_div(mz, rho);
    ke = clip_word(clip_word(fx_mul(mx, u1) + fx_mul(my, u2)) + fx_mul(mz, u3));
    ke = fx_mul(ke, 64'sd1 <<< (FB - 1));
    p = fx_mul(gm1, clip_word(en - ke));
    o.mass_flux   = mx[31:0];
    o.xmom_flux   = 32'(clip_word(fx_mul(mx, u1) + p));
    o.ymom_flux   = 32'(fx_mul(mx, u2));
    o.zmom_flux   = 32'(fx_mul(mx, u3));
    o.energy_flux = 32'(fx_mul(u1, clip_word(en + p)));
    o.mag_y_flux  = 32'(clip_word(-ez));
    o.mag_z_flux  = ey[31:0];
    o.elec_y_flux = 32'(fx_mul(c2, bz));
    o.elec_z_flux = 32'(clip_word(-fx_mul(c2, by)));
    o.saturated   = clip_hit;
    return o;
  endfunction

  // Driver: at each edge a started point is predicted, then the next one is offered.
  always @(posedge clk_i) begin
    if (start && !busy) begin
      owed_fluxes.push_back(flux_of(in_item_i));
      started_points++;
    end
    if (rst_ni && pending_points.size() != 0 && !(start && busy) &&
        $urandom_range(99) >= send_idle_pct) begin
      in_item_i <= pending_points.pop_front();
      start <= 1'b1;
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  task automatic compare_word(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Monitor: every strobed result is checked against the oldest owed one.
  always @(posedge clk_i) begin
    tfpf_out_t want;
    if (rst_ni && out_valid_o) begin
      if (owed_fluxes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        error_count++;
      end else begin
        want = owed_fluxes.pop_front();
        compare_word("mass_flux", want.mass_flux, out_item_o.mass_flux);
        compare_word("xmom_flux", want.xmom_flux, out_item_o.xmom_flux);
        compare_word("ymom_flux", want.ymom_flux, out_item_o.ymom_flux);
        compare_word("zmom_flux", want.zmom_flux, out_item_o.zmom_flux);
        compare_word("energy_flux", want.energy_flux, out_item_o.energy_flux);
        compare_word("mag_y_flux", want.mag_y_flux, out_item_o.mag_y_flux);
        compare_word("mag_z_flux", want.mag_z_flux, out_item_o.mag_z_flux);
        compare_word("elec_y_flux", want.elec_y_flux, out_item_o.elec_y_flux);
        compare_word("elec_z_flux", want.elec_z_flux, out_item_o.elec_z_flux);
        compare_word("density_error", 32'(want.density_error),
                     32'(out_item_o.density_error));
        compare_word("saturated", 32'(want.saturated), 32'(out_item_o.saturated));
        checked_fluxes++;
        density_errors_seen += want.density_error;
        saturations_seen += want.saturated;
      end
    end
  end

  // Register write: setup cycle, then access cycle; the shadow follows once it lands.
  task automatic write_reg(tfpf_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_GAMMA) gamma_shadow = value[GAMMA_W-1:0];
    else light_shadow = value[LIGHT_W-1:0];
  endtask

  // Waits until every started point has been answered, then lets the pipe empty.
  task automatic drain();
    while (pending_points.size() != 0 || start || owed_fluxes.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // Mostly physical points with modest values, some fully random noise.
  function automatic tfpf_in_t random_point();
    tfpf_in_t pt;
    int sel;
    sel = $urandom_range(9);
    pt.density      = rand_word();
    pt.momentum_x   = rand_word();
    pt.momentum_y   = rand_word();
    pt.momentum_z   = rand_word();
    pt.total_energy = rand_word();
    pt.mag_y        = rand_word();
    pt.mag_z        = rand_word();
    pt.elec_y       = rand_word();
    pt.elec_z       = rand_word();
    if (sel < 7) begin
      // Density near one, momenta and energy of a few units: no clipping mostly.
      pt.density      = $urandom_range(32'h0004_0000, 32'h0000_1000);
      pt.momentum_x   = $signed(rand_word()) >>> $urandom_range(22, 12);
      pt.momentum_y   = $signed(rand_word()) >>> $urandom_range(22, 12);
      pt.momentum_z   = $signed(rand_word()) >>> $urandom_range(22, 12);
      pt.total_energy = rand_word() >> $urandom_range(20, 10);
      pt.mag_y        = $signed(rand_word()) >>> $urandom_range(20, 8);
      pt.mag_z        = $signed(rand_word()) >>> $urandom_range(20, 8);
    end else if (sel == 7) begin
      pt.density = $urandom_range(40);
    end
    return pt;
  endfunction

  function automatic tfpf_in_t make_point(logic [31:0] rho, logic [31:0] mx,
                                          logic [31:0] my, logic [31:0] mz,
                                          logic [31:0] en, logic [31:0] fld);
    tfpf_in_t pt;
    pt.density = rho;
    pt.momentum_x = mx;
    pt.momentum_y = my;
    pt.momentum_z = mz;
    pt.total_energy = en;
    pt.mag_y = fld;
    pt.mag_z = ~fld;
    pt.elec_y = ~fld;
    pt.elec_z = fld;
    return pt;
  endfunction

  initial begin
    int idle_plan[4];
    logic [31:0] gammas[6];
    logic [31:0] lights[6];
    rst_ni = 1'b0;
    idle_plan = '{0, 52, 0, 52};
    gammas = '{32'd109227, 32'd65537, 32'd262144, 32'd0, 32'd524287, 32'd98304};
    lights = '{32'd65536, 32'd0, 32'd16777216, 32'd33554431, 32'd131072, 32'd3};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed points: density signs and extremes, extreme momenta, energies and
    // fields, and the negation of the most negative electric field.
    pending_points.push_back(make_point(32'h0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1));
    pending_points.push_back(make_point(32'hffff_ffff, 1, 1, 1, 1, 32'h1));
    pending_points.push_back(make_point(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
    pending_points.push_back(make_point(32'h1_0000, 32'h2_0000, 32'hffff_0000, 32'h8000,
                                        32'h5_0000, 32'h1_0000));
    pending_points.push_back(make_point(32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h1,
                                        32'h7fff_ffff, 32'h8000_0000));
    pending_points.push_back(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    pending_points.push_back(make_point(32'h7fff_ffff, 32'h1, 32'hffff_ffff, 0,
                                        32'hffff_ffff, 32'hffff_ffff));
    pending_points.push_back(make_point(32'h3, 32'h1, 32'h2, 32'hffff_ffff, 0, 0));
    pending_points.push_back(make_point(32'h1_0000, 32'h8000, 32'h8000, 32'hffff_8000,
                                        32'h1, 32'h5555_5555));
    pending_points.push_back(make_point(32'h0000_8000, 32'h0100_0000, 0, 0,
                                        32'h0100_0000, 32'haaaa_aaaa));
    drain();

    // Register settings: each phase runs random points under one setting, idling 0 or 52
    // percent in turn; odd phases switch to 15 percent idling between the halves.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GAMMA, gammas[ph]);
      write_reg(REG_LIGHT, lights[ph]);
      if (ph == 0) begin
        pending_points.push_back(make_point(32'h1_0000, 32'h1_0000, 0, 0, 32'h1_0000,
                                            32'h1_0000));
        drain();
      end
      send_idle_pct = idle_plan[ph % 4];
      for (int n = 0; n < 36; n++) pending_points.push_back(random_point());
      drain();
      if (ph % 2 == 1) send_idle_pct = 15;
      for (int n = 0; n < 36; n++) pending_points.push_back(random_point());
      drain();
    end

    $display("Started %0d points over six register settings; %0d results checked,",
             started_points, checked_fluxes);
    $display("of which %0d had a nonpositive density and %0d clipped.",
             density_errors_seen, saturations_seen);
    if (error_count == 0 && owed_fluxes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timed out waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
